// File: hdl/sorted_priority_queue_core_assert.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// clocked assertion with reset disable
`define SPQ_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked while an output item is shown
`define SPQ_ASSERT_OUT(label, cond, msg) \
	`SPQ_ASSERT_CLK(label, m_tvalid |-> (cond), msg)

`endif

// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
	localparam int STATUS_WIDTH = 2;

	localparam int IN_DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_RAW_WIDTH  = STATUS_WIDTH + VALUE_WIDTH + COUNT_WIDTH;
	localparam int OUT_DATA_WIDTH = ((OUT_RAW_WIDTH + 7) / 8) * 8;

	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_HEAD_LSB   = STATUS_WIDTH;
	localparam int OUT_FILL_LSB   = STATUS_WIDTH + VALUE_WIDTH;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		value_t value;
		logic   cfg_we;
		logic   cfg_mode;
	} spq_cmd_t;

	typedef struct packed {
		logic [STATUS_WIDTH-1:0] status;
		value_t                  head_value;
		count_t                  fill_count;
	} spq_sts_t;

endpackage

// File: hdl/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::spq_cmd_t cmd,
	output spq_pkg::spq_sts_t sts
);

	spq_pkg::value_t entries_q [spq_pkg::DEPTH];
	spq_pkg::count_t count_q;
	logic            mode_q;

	logic [spq_pkg::DEPTH-1:0] lower;
	logic [spq_pkg::DEPTH-1:0] first;
	logic [spq_pkg::DEPTH-1:0] after;
	logic                      full;
	logic                      empty;

	assign full  = (count_q == spq_pkg::COUNT_WIDTH'(spq_pkg::DEPTH));
	assign empty = (count_q == '0);

	// slot at count counts as lower so an insert with no lower entry goes to the tail
	always_comb begin
		for (int i = 0; i < spq_pkg::DEPTH; i++) begin
			lower[i] = ((spq_pkg::COUNT_WIDTH'(i) < count_q) &&
				(mode_q ? (entries_q[i] < cmd.value) : (entries_q[i] > cmd.value))) ||
				(spq_pkg::COUNT_WIDTH'(i) == count_q);
		end
		first = lower & (~lower + spq_pkg::DEPTH'(1));
		after = ~(first - spq_pkg::DEPTH'(1));
	end

	always_comb begin
		sts.status     = spq_pkg::STATUS_DONE;
		sts.head_value = '0;
		sts.fill_count = count_q;
		if (cmd.enq) begin
			if (full) begin
				sts.status = spq_pkg::STATUS_FULL;
			end else begin
				sts.fill_count = count_q + spq_pkg::COUNT_WIDTH'(1);
			end
		end else if (cmd.deq) begin
			if (empty) begin
				sts.status = spq_pkg::STATUS_EMPTY;
			end else begin
				sts.head_value = entries_q[0];
				sts.fill_count = count_q - spq_pkg::COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			if (cmd.cfg_we) begin
				mode_q <= cmd.cfg_mode;
			end
			if ((cmd.enq && !full) || (cmd.deq && !empty)) begin
				count_q <= sts.fill_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq && !full) begin
			if (first[0]) begin
				entries_q[0] <= cmd.value;
			end
			for (int i = 1; i < spq_pkg::DEPTH; i++) begin
				if (first[i]) begin
					entries_q[i] <= cmd.value;
				end else if (after[i]) begin
					entries_q[i] <= entries_q[i-1];
				end
			end
		end else if (cmd.deq && !empty) begin
			for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
				entries_q[i] <= entries_q[i+1];
			end
		end
	end

endmodule

// File: hdl/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spq_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spq_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	output spq_pkg::spq_cmd_t                  cmd,
	input  spq_pkg::spq_sts_t                  sts
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_HOLD  = 1'b1;

	logic                               state_q;
	logic                               state_d;
	logic [spq_pkg::OUT_DATA_WIDTH-1:0] out_q;
	logic                               accept;

	assign s_tready = (state_q == ST_EMPTY) || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_HOLD);
	assign m_tdata  = out_q;

	assign cmd.enq      = accept && (s_tuser == spq_pkg::FUNC_ENQ);
	assign cmd.deq      = accept && (s_tuser == spq_pkg::FUNC_DEQ);
	assign cmd.value    = s_tdata[spq_pkg::VALUE_WIDTH-1:0];
	assign cmd.cfg_we   = cfg_wr_en;
	assign cmd.cfg_mode = cfg_wr_data;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (accept) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (m_tready && !accept) begin
					state_d = ST_EMPTY;
				end
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= spq_pkg::OUT_DATA_WIDTH'({sts.fill_count, sts.head_value, sts.status});
		end
	end

endmodule

// File: hdl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps

// Sorted priority queue of up to 16 signed 32-bit values kept in a shift-register array with
// the head in slot 0. Each input item (tuser 0 enqueue, 1 dequeue) gives exactly one output
// item with status, dequeued head value and fill count. All slots are compared against the new
// value in parallel and the array shifts in the same edge, and the registered output lets a
// new item enter every cycle while m_tready is high. Equal values
// leave in arrival order. cfg_wr_data selects 0 smallest-first, 1 largest-first; write it
// only while no item is in flight. An enqueue into a full queue or a dequeue of an empty one
// leaves the queue unchanged and reports status 1 or 2.
module sorted_priority_queue_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spq_pkg::IN_DATA_WIDTH-1:0]  s_tdata,  // value
	input  logic                               s_tuser,  // func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spq_pkg::OUT_DATA_WIDTH-1:0] m_tdata,  // status, head_value, fill_count
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data
);

	spq_pkg::spq_cmd_t cmd;
	spq_pkg::spq_sts_t sts;

	spq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

	spq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// File: hdl/spq_checker.sv
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_assert.svh"

module spq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [spq_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

	logic [spq_pkg::STATUS_WIDTH-1:0] status;
	spq_pkg::value_t                  head;
	spq_pkg::count_t                  fill;

	assign status = m_tdata[spq_pkg::OUT_STATUS_LSB +: spq_pkg::STATUS_WIDTH];
	assign head   = m_tdata[spq_pkg::OUT_HEAD_LSB +: spq_pkg::VALUE_WIDTH];
	assign fill   = m_tdata[spq_pkg::OUT_FILL_LSB +: spq_pkg::COUNT_WIDTH];

	`SPQ_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output item changed while stalled")
	`SPQ_ASSERT_OUT(a_fill_range, fill <= spq_pkg::COUNT_WIDTH'(spq_pkg::DEPTH), "fill count above depth")
	`SPQ_ASSERT_OUT(a_full_fill, status != spq_pkg::STATUS_FULL || fill == spq_pkg::COUNT_WIDTH'(spq_pkg::DEPTH), "full status with room left")
	`SPQ_ASSERT_OUT(a_empty_fill, status != spq_pkg::STATUS_EMPTY || (fill == '0 && head == '0), "empty status with entries or head")
	`SPQ_ASSERT_CLK(a_ready_free, !m_tvalid |-> s_tready, "input stalled with no output pending")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

// File: tb/sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic   func;
		value_t value;
	} queue_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_WIDTH-1:0] s_tdata = '0;
	logic s_tuser = FUNC_ENQ;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_WIDTH-1:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	queue_op_t ops_pending[$];
	spq_sts_t results_due[$];

	// predicted queue contents, head in slot 0
	value_t q_store[DEPTH];
	int q_count = 0;
	bit largest_first = 1'b0;

	bit idle_on = 1'b1;
	bit hold_tgl = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int send_gap = 0;
	int err_cnt = 0;
	int sent_cnt = 0;
	int checked_cnt = 0;
	int full_cnt = 0;
	int empty_cnt = 0;
	int mode_writes = 0;
	int cycle_cnt = 0;
	queue_op_t next_op;
	spq_sts_t want;

	sorted_priority_queue_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	function automatic bit ranks_below(value_t stored, value_t incoming);
		return largest_first ? (stored < incoming) : (stored > incoming);
	endfunction

	task automatic apply_op(input logic func, input value_t val);
		spq_sts_t r;
		int pos;
		r.status = STATUS_DONE;
		r.head_value = '0;
		if (func == FUNC_ENQ) begin
			if (q_count >= DEPTH) begin
				r.status = STATUS_FULL;
				full_cnt++;
			end else begin
				pos = q_count;
				for (int i = 0; i < q_count; i++)
					if (pos == q_count && ranks_below(q_store[i], val))
						pos = i;
				for (int i = q_count; i > pos; i--)
					q_store[i] = q_store[i-1];
				q_store[pos] = val;
				q_count++;
			end
		end else begin
			if (q_count == 0) begin
				r.status = STATUS_EMPTY;
				empty_cnt++;
			end else begin
				r.head_value = q_store[0];
				for (int i = 1; i < q_count; i++)
					q_store[i-1] = q_store[i];
				q_count--;
			end
		end
		r.fill_count = count_t'(q_count);
		results_due.push_back(r);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (err_cnt < 10)
			$display("mismatch in %s of result %0d: expected %h, got %h",
				field, checked_cnt, exp_v, got_v);
		err_cnt++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FUNC_ENQ;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_op(s_tuser, value_t'(s_tdata[VALUE_WIDTH-1:0]));
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (idle_on && ops_pending.size() > 0 && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 13);
					s_tvalid <= 1'b0;
				end else if (ops_pending.size() > 0) begin
					next_op = ops_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_op.value;
					s_tuser <= next_op.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					if (err_cnt < 10)
						$display("result with no operation waiting: %h", m_tdata);
					err_cnt++;
				end else begin
					want = results_due.pop_front();
					if (m_tdata[OUT_STATUS_LSB +: STATUS_WIDTH] !== want.status)
						report_mismatch("status", want.status,
							m_tdata[OUT_STATUS_LSB +: STATUS_WIDTH]);
					if (m_tdata[OUT_HEAD_LSB +: VALUE_WIDTH] !== want.head_value)
						report_mismatch("head_value", want.head_value,
							m_tdata[OUT_HEAD_LSB +: VALUE_WIDTH]);
					if (m_tdata[OUT_FILL_LSB +: COUNT_WIDTH] !== want.fill_count)
						report_mismatch("fill_count", want.fill_count,
							m_tdata[OUT_FILL_LSB +: COUNT_WIDTH]);
					checked_cnt++;
				end
			end
			if (hold_tgl != hold_seen) begin
				hold_seen = hold_tgl;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, results_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_op(input logic func, input value_t val);
		queue_op_t op;
		op.func = func;
		op.value = val;
		ops_pending.push_back(op);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (ops_pending.size() > 0 || s_tvalid || results_due.size() > 0);
	endtask

	task automatic write_mode(input bit mode);
		wait_drained();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		largest_first = mode;
		mode_writes++;
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(0, 5))
			0: return value_t'(int'($urandom_range(0, 8)) - 4);
			1: return value_t'(int'($urandom_range(0, 200)) - 100);
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	// runs that lean toward enqueue or dequeue so the queue swings between full and empty
	task automatic queue_random_ops(input int n_ops, input int enq_lean);
		int run_len;
		int enq_pct;
		int made;
		made = 0;
		while (made < n_ops) begin
			run_len = $urandom_range(1, 24);
			enq_pct = $urandom_range(0, 99) < enq_lean ? 85 : 15;
			for (int i = 0; i < run_len && made < n_ops; i++) begin
				if ($urandom_range(0, 99) < enq_pct)
					push_op(FUNC_ENQ, pick_value());
				else
					push_op(FUNC_DEQ, value_t'($urandom));
				made++;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		write_mode(1'b0);

		push_op(FUNC_DEQ, 32'h1234_5678);
		push_op(FUNC_ENQ, 32'h7FFF_FFFF);
		push_op(FUNC_ENQ, 32'h8000_0000);
		push_op(FUNC_ENQ, 32'h0000_0000);
		push_op(FUNC_ENQ, 32'hFFFF_FFFF);
		push_op(FUNC_ENQ, 32'd1);
		push_op(FUNC_ENQ, 32'd5);
		push_op(FUNC_ENQ, 32'd5);
		push_op(FUNC_ENQ, -32'sd5);
		push_op(FUNC_ENQ, 32'd3);
		push_op(FUNC_ENQ, 32'd3);
		push_op(FUNC_ENQ, 32'd100);
		push_op(FUNC_ENQ, -32'sd100);
		push_op(FUNC_ENQ, 32'h7FFF_FFFE);
		push_op(FUNC_ENQ, 32'h8000_0001);
		push_op(FUNC_ENQ, 32'hAAAA_5555);
		push_op(FUNC_ENQ, 32'h5555_AAAA);
		push_op(FUNC_ENQ, 32'd9);
		// switch to largest first with the queue full, stored order stays
		write_mode(1'b1);
		push_op(FUNC_DEQ, 32'hFFFF_FFFF);
		push_op(FUNC_ENQ, 32'd0);
		push_op(FUNC_ENQ, 32'h7FFF_FFFF);
		push_op(FUNC_DEQ, 32'h0);
		push_op(FUNC_DEQ, 32'h0);

		write_mode(1'b1);
		queue_random_ops(165, 50);
		write_mode(1'b0);
		queue_random_ops(165, 50);

		// long receiver hold while the sender keeps offering
		write_mode(1'b1);
		hold_tgl = ~hold_tgl;
		queue_random_ops(165, 70);

		write_mode(1'b0);
		queue_random_ops(165, 40);

		write_mode(1'b1);
		@(negedge clk);
		idle_on = 1'b0;
		queue_random_ops(150, 50);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d operations sent, %0d results checked, %0d order mode writes",
			sent_cnt, checked_cnt, mode_writes);
		$display("%0d rejected enqueues on a full queue, %0d rejected dequeues on an empty one",
			full_cnt, empty_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
